FILE: hdl/tdas_pkg.sv
// Package: widths, register indexes, reset values and the config bundle type.
`timescale 1ns / 1ps
package tdas_pkg;

   localparam int ClockWidth = 24;
   localparam int FreqWidth  = 16;
   localparam int DivWidth   = 16;
   localparam int TickWidth  = 8;
   localparam int TypeWidth  = 2;
   localparam int CsrIdxWidth = 3;

   // Request codes
   localparam logic [TypeWidth-1:0] REQ_TICK  = 2'd0;
   localparam logic [TypeWidth-1:0] REQ_TONE  = 2'd1;
   localparam logic [TypeWidth-1:0] REQ_BEEP  = 2'd2;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_BASE_CLOCK = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_FREQ   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MIN_DIV    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_BEEP_FREQ  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_BEEP_TICKS = 3'd4;

   // Reset values
   localparam logic [ClockWidth-1:0] RST_BASE_CLOCK = 24'd1193182;
   localparam logic [FreqWidth-1:0]  RST_MAX_FREQ   = 16'd20000;
   localparam logic [DivWidth-1:0]   RST_MIN_DIV    = 16'd2;
   localparam logic [FreqWidth-1:0]  RST_BEEP_FREQ  = 16'd880;
   localparam logic [TickWidth-1:0]  RST_BEEP_TICKS = 8'd2;

   typedef struct packed {
      logic [ClockWidth-1:0] base_clock_hz;
      logic [FreqWidth-1:0]  max_freq;
      logic [DivWidth-1:0]   min_divisor;
      logic [FreqWidth-1:0]  beep_freq;
      logic [TickWidth-1:0]  beep_ticks;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: hdl/tdas_ifs.sv
// Interfaces: request, response and register-write channels.
`timescale 1ns / 1ps
interface tdas_req_if;
   logic                          valid;
   logic                          ready;
   logic [tdas_pkg::TypeWidth-1:0] req_type;
   logic [tdas_pkg::FreqWidth-1:0] tone_freq;
   modport source (output valid, req_type, tone_freq, input ready);
   modport sink   (input valid, req_type, tone_freq, output ready);
endinterface

interface tdas_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tdas_pkg::DivWidth-1:0]  divisor_value;
   logic                          divisor_written;
   logic                          speaker_on;
   logic [tdas_pkg::FreqWidth-1:0] playing_freq;
   modport source (output valid, divisor_value, divisor_written, speaker_on, playing_freq,
                   input ready);
   modport sink   (input valid, divisor_value, divisor_written, speaker_on, playing_freq,
                   output ready);
endinterface

interface tdas_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tdas_pkg::CsrIdxWidth-1:0] index;
   logic [tdas_pkg::ClockWidth-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/tdas_csr.sv
// Configuration register bank written through the register channel.
`timescale 1ns / 1ps
module tdas_csr (
   input  logic                 clock,
   input  logic                 reset,
   tdas_csr_if.sink             csr_chan,
   output tdas_pkg::cfg_type    cfg
);

   tdas_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            tdas_pkg::CSR_BASE_CLOCK: cfg_in.base_clock_hz = csr_chan.data;
            tdas_pkg::CSR_MAX_FREQ:   cfg_in.max_freq = csr_chan.data[tdas_pkg::FreqWidth-1:0];
            tdas_pkg::CSR_MIN_DIV:    cfg_in.min_divisor = csr_chan.data[tdas_pkg::DivWidth-1:0];
            tdas_pkg::CSR_BEEP_FREQ:  cfg_in.beep_freq = csr_chan.data[tdas_pkg::FreqWidth-1:0];
            tdas_pkg::CSR_BEEP_TICKS: cfg_in.beep_ticks = csr_chan.data[tdas_pkg::TickWidth-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_clock_hz <= tdas_pkg::RST_BASE_CLOCK;
         cfg_ff.max_freq      <= tdas_pkg::RST_MAX_FREQ;
         cfg_ff.min_divisor   <= tdas_pkg::RST_MIN_DIV;
         cfg_ff.beep_freq     <= tdas_pkg::RST_BEEP_FREQ;
         cfg_ff.beep_ticks    <= tdas_pkg::RST_BEEP_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/tdas_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module tdas_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tdas_pkg::ClockWidth-1:0]   dividend,
   input  logic [tdas_pkg::FreqWidth-1:0]    divisor,
   output tdas_pkg::div_status_type          status,
   output logic [tdas_pkg::ClockWidth-1:0]   quotient
);

   localparam int CntWidth = $clog2(tdas_pkg::ClockWidth + 1);

   logic [tdas_pkg::ClockWidth-1:0] num_ff, num_in;
   logic [tdas_pkg::FreqWidth-1:0]  rem_ff, rem_in;
   logic [tdas_pkg::FreqWidth-1:0]  dsr_ff, dsr_in;
   logic [CntWidth-1:0]             cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [tdas_pkg::FreqWidth:0]    trial;
   logic [tdas_pkg::FreqWidth:0]    diff;
   logic                            fits;

   assign trial = {rem_ff, num_ff[tdas_pkg::ClockWidth-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CntWidth'(tdas_pkg::ClockWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when the divisor fits
         num_in = {num_ff[tdas_pkg::ClockWidth-2:0], fits};
         rem_in = fits ? diff[tdas_pkg::FreqWidth-1:0] : trial[tdas_pkg::FreqWidth-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;

endmodule

FILE: hdl/tone_divider_with_auto_silence_top.sv
// Top level: tone controller with timer divisor computation and beep auto silence.
`timescale 1ns / 1ps
// Usage:
//   req_chan carries one transaction per request: req_type (tick, set tone,
//   short beep) and tone_freq. rsp_chan returns exactly one transaction per
//   request with the loaded divisor, a reload flag, the speaker enable and
//   the sounding frequency. csr_chan writes the five configuration
//   registers by index; it is always ready and should be used while idle.
//   Timing: a request that loads a new divisor runs a bit-serial divide of
//   the 24-bit timer clock by the clamped frequency, one quotient bit per
//   cycle. Its response passes through the divide state, the emit state and
//   the output register; the next request is taken once it is registered.
//   Ticks, silencing and ignored request codes skip the divider and go
//   straight to the emit state. The divider is the bottleneck: one
//   request is in work at a time.
//   The response sits in an output register; the next request is accepted
//   while it waits. When the receiver stalls and a new result is ready,
//   the controller holds it until the output register frees up.
//   Reset (synchronous, active high) silences the speaker, disarms the
//   countdown, zeroes the loaded divisor and restores register defaults.
module tone_divider_with_auto_silence_top (
   input  logic       clock,
   input  logic       reset,
   tdas_req_if.sink   req_chan,
   tdas_rsp_if.source rsp_chan,
   tdas_csr_if.sink   csr_chan
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   tdas_pkg::cfg_type        cfg;
   tdas_pkg::div_status_type div_status;
   logic [tdas_pkg::ClockWidth-1:0] quotient;

   logic [1:0]                      state_ff, state_in;
   logic [tdas_pkg::FreqWidth-1:0]  sound_ff, sound_in;
   logic [tdas_pkg::TickWidth-1:0]  count_ff, count_in;
   logic [tdas_pkg::DivWidth-1:0]   ldiv_ff, ldiv_in;
   logic [tdas_pkg::FreqWidth-1:0]  pend_ff, pend_in;
   logic                            wr_ff, wr_in;
   logic                            ovalid_ff, ovalid_in;
   logic [tdas_pkg::DivWidth-1:0]   odiv_ff, odiv_in;
   logic                            owr_ff, owr_in;
   logic [tdas_pkg::FreqWidth-1:0]  ofreq_ff, ofreq_in;

   logic                            accept;
   logic                            div_start;
   logic [tdas_pkg::FreqWidth-1:0]  pick_freq;
   logic [tdas_pkg::FreqWidth-1:0]  clamp_freq;
   logic [tdas_pkg::DivWidth-1:0]   raised_div;
   logic                            out_free;

   tdas_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   tdas_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.base_clock_hz),
      .divisor  (clamp_freq),
      .status   (div_status),
      .quotient (quotient)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !ovalid_ff || rsp_chan.ready;

   // Beep plays the configured tone; clamp to the configured maximum.
   assign pick_freq  = (req_chan.req_type == tdas_pkg::REQ_BEEP) ? cfg.beep_freq
                                                                 : req_chan.tone_freq;
   assign clamp_freq = (pick_freq > cfg.max_freq) ? cfg.max_freq : pick_freq;

   // Raise the quotient to the minimum divisor, then keep the low 16 bits.
   assign raised_div = (quotient < {8'd0, cfg.min_divisor}) ? cfg.min_divisor
                                                            : quotient[tdas_pkg::DivWidth-1:0];

   always_comb begin
      state_in  = state_ff;
      sound_in  = sound_ff;
      count_in  = count_ff;
      ldiv_in   = ldiv_ff;
      pend_in   = pend_ff;
      wr_in     = wr_ff;
      div_start = 1'b0;
      ovalid_in = ovalid_ff && !rsp_chan.ready;
      odiv_in   = odiv_ff;
      owr_in    = owr_ff;
      ofreq_in  = ofreq_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_in    = 1'b0;
               pend_in  = clamp_freq;
               state_in = ST_EMIT;
               case (req_chan.req_type) inside
                  tdas_pkg::REQ_TICK: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                        if (count_ff == tdas_pkg::TickWidth'(1)) begin
                           sound_in = '0;
                        end
                     end
                  end
                  tdas_pkg::REQ_TONE, tdas_pkg::REQ_BEEP: begin
                     if (req_chan.req_type == tdas_pkg::REQ_BEEP) begin
                        count_in = cfg.beep_ticks;
                     end
                     if (clamp_freq == '0) begin
                        sound_in = '0;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: ;  // ignore the unused code
               endcase
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               ldiv_in  = raised_div;
               sound_in = pend_ff;
               wr_in    = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odiv_in   = ldiv_ff;
               owr_in    = wr_ff;
               ofreq_in  = sound_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sound_ff  <= '0;
         count_ff  <= '0;
         ldiv_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sound_ff  <= sound_in;
         count_ff  <= count_in;
         ldiv_ff   <= ldiv_in;
         ovalid_ff <= ovalid_in;
      end
      pend_ff  <= pend_in;
      wr_ff    <= wr_in;
      odiv_ff  <= odiv_in;
      owr_ff   <= owr_in;
      ofreq_ff <= ofreq_in;
   end

   assign rsp_chan.valid           = ovalid_ff;
   assign rsp_chan.divisor_value   = odiv_ff;
   assign rsp_chan.divisor_written = owr_ff;
   assign rsp_chan.speaker_on      = (ofreq_ff != '0);
   assign rsp_chan.playing_freq    = ofreq_ff;

endmodule
